// ===== rtl/ifst_pkg.sv =====
// Shared types, widths, operation codes and helper functions for the IMU frame
// smoother and tilt unit. No dependencies.
package ifst_pkg;

	localparam int FRAME_LENGTH      = 14;
	localparam int FRACTION_BITS_DEF = 8;
	localparam int CORDIC_STEPS_DEF  = 16;

	localparam logic [3:0] LAST_BYTE = 4'(FRAME_LENGTH - 1);

	localparam logic [15:0] WEIGHT_RESET = 16'd52429;
	localparam logic [15:0] GSCALE_RESET = 16'd1001;

	localparam int MUL_W  = 25;
	localparam int PRD_W  = 50;
	localparam int SUM_W  = 52;
	localparam int RAD_W  = 48;
	localparam int ROOT_W = 24;
	localparam int REM_W  = 27;
	localparam int CX_W   = 45;
	localparam int Z_W    = 27;
	localparam int ANG_W  = 17;

	localparam int ANGLE_LIMIT = 46080;
	localparam int ANG_SHIFT   = 8;
	localparam int ANG_HALF    = 128;
	localparam int BASE_180    = 180 * 65536;

	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_IDLE  = 4'd0;
	localparam logic [OP_W-1:0] OP_SM_A  = 4'd1;
	localparam logic [OP_W-1:0] OP_SM_B  = 4'd2;
	localparam logic [OP_W-1:0] OP_SM_C  = 4'd3;
	localparam logic [OP_W-1:0] OP_RT_A  = 4'd4;
	localparam logic [OP_W-1:0] OP_RT_B  = 4'd5;
	localparam logic [OP_W-1:0] OP_SQ_A  = 4'd6;
	localparam logic [OP_W-1:0] OP_SQ_B  = 4'd7;
	localparam logic [OP_W-1:0] OP_SQ_C  = 4'd8;
	localparam logic [OP_W-1:0] OP_SQRT  = 4'd9;
	localparam logic [OP_W-1:0] OP_CINIT = 4'd10;
	localparam logic [OP_W-1:0] OP_CSTEP = 4'd11;
	localparam logic [OP_W-1:0] OP_CFIN  = 4'd12;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [1:0]      sel;
		logic [4:0]      iter;
		logic            byte_we;
		logic [3:0]      byte_idx;
		logic            load_out;
	} ifst_cmd_t;

	function automatic logic signed [23:0] sat24(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'(8388607);
		lo = SUM_W'(-8388608);
		if (v > hi)
			sat24 = 24'sh7FFFFF;
		else if (v < lo)
			sat24 = 24'sh800000;
		else
			sat24 = v[23:0];
	endfunction

	// atan(2^-i) in degrees, Q.16
	function automatic logic [22:0] atan_q16(input logic [4:0] i);
		case (i)
			5'd0:  atan_q16 = 23'd2949120;
			5'd1:  atan_q16 = 23'd1740967;
			5'd2:  atan_q16 = 23'd919879;
			5'd3:  atan_q16 = 23'd466945;
			5'd4:  atan_q16 = 23'd234379;
			5'd5:  atan_q16 = 23'd117304;
			5'd6:  atan_q16 = 23'd58666;
			5'd7:  atan_q16 = 23'd29335;
			5'd8:  atan_q16 = 23'd14668;
			5'd9:  atan_q16 = 23'd7334;
			5'd10: atan_q16 = 23'd3667;
			5'd11: atan_q16 = 23'd1833;
			5'd12: atan_q16 = 23'd917;
			5'd13: atan_q16 = 23'd458;
			5'd14: atan_q16 = 23'd229;
			5'd15: atan_q16 = 23'd115;
			5'd16: atan_q16 = 23'd57;
			5'd17: atan_q16 = 23'd29;
			5'd18: atan_q16 = 23'd14;
			5'd19: atan_q16 = 23'd7;
			5'd20: atan_q16 = 23'd4;
			5'd21: atan_q16 = 23'd2;
			5'd22: atan_q16 = 23'd1;
			default: atan_q16 = 23'd0;
		endcase
	endfunction

endpackage

// ===== rtl/ifst_dp.sv =====
// Datapath: byte assembly, raw stores, shared multiplier, smoother, rate scaling,
// bit-serial square root, CORDIC vectoring and result registers. Uses ifst_pkg.
module ifst_dp #(
	parameter int FRACTION_BITS = ifst_pkg::FRACTION_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ifst_pkg::ifst_cmd_t       cmd,
	input  logic [7:0]                data_byte,
	input  logic [15:0]               smoothing_weight,
	input  logic [15:0]               gyro_scale,
	output logic signed [23:0]        accel_x_smooth,
	output logic signed [23:0]        accel_y_smooth,
	output logic signed [23:0]        accel_z_smooth,
	output logic signed [23:0]        rate_x,
	output logic signed [23:0]        rate_y,
	output logic signed [23:0]        rate_z,
	output logic signed [16:0]        roll_angle,
	output logic signed [16:0]        pitch_angle
);

	localparam int RSH  = 16 - FRACTION_BITS;
	localparam int HALF = (FRACTION_BITS < 16) ? 2 ** (15 - FRACTION_BITS) : 0;

	logic [7:0]                          held_q;
	logic [15:0]                         raw_accel_q [3];
	logic [15:0]                         raw_rate_q [3];
	logic signed [23:0]                  sm_q [3];
	logic signed [23:0]                  rate_q [3];
	logic signed [ifst_pkg::ANG_W-1:0]   angle_q [2];
	logic                                first_q;
	logic signed [ifst_pkg::PRD_W-1:0]   prod_q;
	logic signed [ifst_pkg::PRD_W-1:0]   acc_q;
	logic [ifst_pkg::RAD_W-1:0]          rad_q;
	logic [ifst_pkg::REM_W-1:0]          rem_q;
	logic [ifst_pkg::ROOT_W-1:0]         root_q;
	logic signed [ifst_pkg::CX_W-1:0]    cx_q;
	logic signed [ifst_pkg::CX_W-1:0]    cy_q;
	logic signed [ifst_pkg::Z_W-1:0]     z_q;
	logic signed [ifst_pkg::Z_W-1:0]     base_q;
	logic                                zero_q;

	logic signed [ifst_pkg::MUL_W-1:0]   mul_a;
	logic signed [ifst_pkg::MUL_W-1:0]   mul_b;
	logic [16:0]                         w_new;
	logic signed [ifst_pkg::SUM_W-1:0]   sm_sum;
	logic signed [ifst_pkg::SUM_W-1:0]   target;
	logic signed [23:0]                  sm_new;
	logic signed [ifst_pkg::SUM_W-1:0]   rt_sum;
	logic signed [23:0]                  rt_new;
	logic [ifst_pkg::REM_W-1:0]          rem_n;
	logic [ifst_pkg::REM_W-1:0]          trial;
	logic signed [ifst_pkg::MUL_W-1:0]   yin;
	logic signed [ifst_pkg::MUL_W-1:0]   ysel;
	logic                                az_pos;
	logic                                x_neg;
	logic signed [ifst_pkg::CX_W-1:0]    xs;
	logic signed [ifst_pkg::CX_W-1:0]    ys;
	logic signed [ifst_pkg::Z_W-1:0]     at;
	logic signed [ifst_pkg::Z_W-1:0]     zs;
	logic signed [ifst_pkg::Z_W-1:0]     zr;
	logic signed [ifst_pkg::ANG_W-1:0]   ang_new;
	logic [3:0]                          rate_off;
	logic [15:0]                         word;

	assign w_new  = 17'd65536 - {1'b0, smoothing_weight};
	assign word   = {held_q, data_byte};
	assign rate_off = cmd.byte_idx - 4'd8;

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			ifst_pkg::OP_SM_A: begin
				mul_a = {sm_q[cmd.sel][23], sm_q[cmd.sel]};
				mul_b = {9'b0, smoothing_weight};
			end
			ifst_pkg::OP_SM_B: begin
				mul_a = {{9{raw_accel_q[cmd.sel][15]}}, raw_accel_q[cmd.sel]};
				mul_b = {8'b0, w_new};
			end
			ifst_pkg::OP_RT_A: begin
				mul_a = {{9{raw_rate_q[cmd.sel][15]}}, raw_rate_q[cmd.sel]};
				mul_b = {9'b0, gyro_scale};
			end
			ifst_pkg::OP_SQ_A: begin
				if (cmd.sel == 2'd0) begin
					mul_a = {sm_q[1][23], sm_q[1]};
				end else begin
					mul_a = {sm_q[0][23], sm_q[0]};
				end
				mul_b = mul_a;
			end
			ifst_pkg::OP_SQ_B: begin
				mul_a = {sm_q[2][23], sm_q[2]};
				mul_b = mul_a;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		sm_sum = {{2{acc_q[ifst_pkg::PRD_W-1]}}, acc_q}
			+ ({{2{prod_q[ifst_pkg::PRD_W-1]}}, prod_q} <<< FRACTION_BITS);
		target = {{(ifst_pkg::SUM_W-16){raw_accel_q[cmd.sel][15]}}, raw_accel_q[cmd.sel]}
			<<< FRACTION_BITS;
		if (first_q)
			sm_new = ifst_pkg::sat24(target);
		else
			sm_new = ifst_pkg::sat24(sm_sum >>> 16);
		rt_sum = {{2{prod_q[ifst_pkg::PRD_W-1]}}, prod_q} + ifst_pkg::SUM_W'(HALF);
		rt_new = ifst_pkg::sat24(rt_sum >>> RSH);
	end

	// one root bit per step
	assign rem_n = {rem_q[ifst_pkg::REM_W-3:0], rad_q[ifst_pkg::RAD_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};

	// roll: atan2(ax, m); pitch: atan2(-ay, m); m takes the opposite sign of az
	always_comb begin
		if (cmd.sel == 2'd0)
			yin = {sm_q[0][23], sm_q[0]};
		else
			yin = -{sm_q[1][23], sm_q[1]};
		az_pos = !sm_q[2][23] && (sm_q[2] != 24'sd0);
		x_neg  = az_pos && (root_q != '0);
		ysel   = x_neg ? -yin : yin;
	end

	always_comb begin
		xs = cx_q >>> cmd.iter;
		ys = cy_q >>> cmd.iter;
		at = $signed({4'b0, ifst_pkg::atan_q16(cmd.iter)});
		zs = z_q + base_q + ifst_pkg::Z_W'(ifst_pkg::ANG_HALF);
		zr = zs >>> ifst_pkg::ANG_SHIFT;
		if (zero_q)
			ang_new = '0;
		else if (zr > ifst_pkg::Z_W'(ifst_pkg::ANGLE_LIMIT))
			ang_new = ifst_pkg::ANG_W'(ifst_pkg::ANGLE_LIMIT);
		else if (zr < ifst_pkg::Z_W'(-ifst_pkg::ANGLE_LIMIT))
			ang_new = ifst_pkg::ANG_W'(-ifst_pkg::ANGLE_LIMIT);
		else
			ang_new = zr[ifst_pkg::ANG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			first_q <= 1'b1;
			for (int i = 0; i < 3; i++) begin
				sm_q[i] <= '0;
			end
		end else begin
			if (cmd.byte_we && !cmd.byte_idx[0]) begin
				held_q <= data_byte;
			end
			if (cmd.op == ifst_pkg::OP_SM_C) begin
				sm_q[cmd.sel] <= sm_new;
				if (cmd.sel == 2'd2) begin
					first_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.byte_we && cmd.byte_idx[0]) begin
			if (cmd.byte_idx < 4'd6) begin
				raw_accel_q[cmd.byte_idx[2:1]] <= word;
			end else if (cmd.byte_idx >= 4'd9) begin
				raw_rate_q[rate_off[2:1]] <= word;
			end
		end

		prod_q <= mul_a * mul_b;

		case (cmd.op)
			ifst_pkg::OP_SM_B: begin
				acc_q <= prod_q + ifst_pkg::PRD_W'(32768);
			end
			ifst_pkg::OP_RT_B: begin
				rate_q[cmd.sel] <= rt_new;
			end
			ifst_pkg::OP_SQ_B: begin
				acc_q <= prod_q;
			end
			ifst_pkg::OP_SQ_C: begin
				rad_q  <= acc_q[ifst_pkg::RAD_W-1:0] + prod_q[ifst_pkg::RAD_W-1:0];
				rem_q  <= '0;
				root_q <= '0;
			end
			ifst_pkg::OP_SQRT: begin
				rad_q <= rad_q << 2;
				if (rem_n >= trial) begin
					rem_q  <= rem_n - trial;
					root_q <= {root_q[ifst_pkg::ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= rem_n;
					root_q <= {root_q[ifst_pkg::ROOT_W-2:0], 1'b0};
				end
			end
			ifst_pkg::OP_CINIT: begin
				cx_q   <= ifst_pkg::CX_W'({root_q, 16'b0});
				cy_q   <= ifst_pkg::CX_W'($signed({ysel, 16'b0}));
				z_q    <= '0;
				zero_q <= (root_q == '0) && (yin == '0);
				if (!x_neg)
					base_q <= '0;
				else if (!yin[ifst_pkg::MUL_W-1])
					base_q <= ifst_pkg::Z_W'(ifst_pkg::BASE_180);
				else
					base_q <= ifst_pkg::Z_W'(-ifst_pkg::BASE_180);
			end
			ifst_pkg::OP_CSTEP: begin
				if (!cy_q[ifst_pkg::CX_W-1]) begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					z_q  <= z_q + at;
				end else begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					z_q  <= z_q - at;
				end
			end
			ifst_pkg::OP_CFIN: begin
				angle_q[cmd.sel[0]] <= ang_new;
			end
			default: begin
			end
		endcase

		if (cmd.load_out) begin
			accel_x_smooth <= sm_q[0];
			accel_y_smooth <= sm_q[1];
			accel_z_smooth <= sm_q[2];
			rate_x         <= rate_q[0];
			rate_y         <= rate_q[1];
			rate_z         <= rate_q[2];
			roll_angle     <= angle_q[0];
			pitch_angle    <= angle_q[1];
		end
	end

endmodule

// ===== rtl/ifst_ctrl.sv =====
// Controller: byte position tracking, compute sequencer and output handshake.
// Drives the datapath through ifst_pkg::ifst_cmd_t.
module ifst_ctrl #(
	parameter int CORDIC_STEPS = ifst_pkg::CORDIC_STEPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                frame_start,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output ifst_pkg::ifst_cmd_t cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SM_A  = 4'd1;
	localparam logic [3:0] S_SM_B  = 4'd2;
	localparam logic [3:0] S_SM_C  = 4'd3;
	localparam logic [3:0] S_RT_A  = 4'd4;
	localparam logic [3:0] S_RT_B  = 4'd5;
	localparam logic [3:0] S_SQ_A  = 4'd6;
	localparam logic [3:0] S_SQ_B  = 4'd7;
	localparam logic [3:0] S_SQ_C  = 4'd8;
	localparam logic [3:0] S_SQRT  = 4'd9;
	localparam logic [3:0] S_CINIT = 4'd10;
	localparam logic [3:0] S_CSTEP = 4'd11;
	localparam logic [3:0] S_CFIN  = 4'd12;
	localparam logic [3:0] S_OUT   = 4'd13;

	localparam logic [4:0] SQRT_LAST  = 5'(ifst_pkg::ROOT_W - 1);
	localparam logic [4:0] CSTEP_LAST = 5'(CORDIC_STEPS - 1);

	logic [3:0] state_q;
	logic [3:0] pos_q;
	logic [1:0] sel_q;
	logic [4:0] cnt_q;
	logic       out_valid_q;

	logic       in_acc;
	logic       take;
	logic [3:0] idx;
	logic       out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign in_acc    = in_valid && !in_stall;
	assign idx       = frame_start ? 4'd0 : pos_q;
	// bytes with no frame open are dropped
	assign take      = in_acc && (frame_start || (pos_q != 4'd0));
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		cmd.sel      = sel_q;
		cmd.iter     = cnt_q;
		cmd.byte_we  = take;
		cmd.byte_idx = idx;
		cmd.load_out = (state_q == S_OUT) && out_free;
		case (state_q)
			S_SM_A:  cmd.op = ifst_pkg::OP_SM_A;
			S_SM_B:  cmd.op = ifst_pkg::OP_SM_B;
			S_SM_C:  cmd.op = ifst_pkg::OP_SM_C;
			S_RT_A:  cmd.op = ifst_pkg::OP_RT_A;
			S_RT_B:  cmd.op = ifst_pkg::OP_RT_B;
			S_SQ_A:  cmd.op = ifst_pkg::OP_SQ_A;
			S_SQ_B:  cmd.op = ifst_pkg::OP_SQ_B;
			S_SQ_C:  cmd.op = ifst_pkg::OP_SQ_C;
			S_SQRT:  cmd.op = ifst_pkg::OP_SQRT;
			S_CINIT: cmd.op = ifst_pkg::OP_CINIT;
			S_CSTEP: cmd.op = ifst_pkg::OP_CSTEP;
			S_CFIN:  cmd.op = ifst_pkg::OP_CFIN;
			default: cmd.op = ifst_pkg::OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pos_q       <= 4'd0;
			sel_q       <= 2'd0;
			cnt_q       <= 5'd0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result loaded in S_OUT keeps valid high
			if (out_valid_q && !out_stall && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				pos_q <= (idx == ifst_pkg::LAST_BYTE) ? 4'd0 : idx + 4'd1;
			end
			case (state_q)
				S_IDLE: begin
					if (take && (idx == ifst_pkg::LAST_BYTE)) begin
						state_q <= S_SM_A;
						sel_q   <= 2'd0;
					end
				end
				S_SM_A: state_q <= S_SM_B;
				S_SM_B: state_q <= S_SM_C;
				S_SM_C: begin
					if (sel_q == 2'd2) begin
						state_q <= S_RT_A;
						sel_q   <= 2'd0;
					end else begin
						state_q <= S_SM_A;
						sel_q   <= sel_q + 2'd1;
					end
				end
				S_RT_A: state_q <= S_RT_B;
				S_RT_B: begin
					if (sel_q == 2'd2) begin
						state_q <= S_SQ_A;
						sel_q   <= 2'd0;
					end else begin
						state_q <= S_RT_A;
						sel_q   <= sel_q + 2'd1;
					end
				end
				S_SQ_A: state_q <= S_SQ_B;
				S_SQ_B: state_q <= S_SQ_C;
				S_SQ_C: begin
					state_q <= S_SQRT;
					cnt_q   <= 5'd0;
				end
				S_SQRT: begin
					if (cnt_q == SQRT_LAST) begin
						state_q <= S_CINIT;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				S_CINIT: begin
					state_q <= S_CSTEP;
					cnt_q   <= 5'd0;
				end
				S_CSTEP: begin
					if (cnt_q == CSTEP_LAST) begin
						state_q <= S_CFIN;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				S_CFIN: begin
					if (sel_q == 2'd1) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_SQ_A;
						sel_q   <= 2'd1;
					end
				end
				S_OUT: begin
					// hold until the output register is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_last_byte_starts: assert property (@(posedge clk) disable iff (!arst_n)
		take && (idx == ifst_pkg::LAST_BYTE) |=> state_q == S_SM_A)
		else $error("last byte did not start the compute sequence");

	a_pos_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= ifst_pkg::LAST_BYTE)
		else $error("byte position outside the frame");

	a_cstep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CSTEP |-> cnt_q <= CSTEP_LAST)
		else $error("CORDIC step count overran");

	a_out_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) && out_free |=> out_valid_q && (state_q == S_IDLE))
		else $error("result not presented after load");

endmodule

// ===== rtl/imu_frame_smooth_and_tilt_unit.sv =====
// Top level of the IMU frame smoother and tilt unit: APB register file plus the
// controller and datapath. Uses ifst_pkg, ifst_ctrl and ifst_dp.
//
// Bytes of a 14-byte sensor burst are taken one per cycle while the unit is idle.
// After the 14th byte the input stalls while the unit computes: three steps per
// accel axis and two per gyro axis on one shared multiplier, then per angle a
// 24-bit square root (one root bit a cycle) and one CORDIC rotation a cycle. If
// the previous result has not been taken when the sequence ends, the stall lasts
// until it is.
module imu_frame_smooth_and_tilt_unit #(
	parameter int FRACTION_BITS = ifst_pkg::FRACTION_BITS_DEF,
	parameter int CORDIC_STEPS  = ifst_pkg::CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         data_byte,
	input  logic               frame_start,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [23:0] accel_x_smooth,
	output logic signed [23:0] accel_y_smooth,
	output logic signed [23:0] accel_z_smooth,
	output logic signed [23:0] rate_x,
	output logic signed [23:0] rate_y,
	output logic signed [23:0] rate_z,
	output logic signed [16:0] roll_angle,
	output logic signed [16:0] pitch_angle
);

	logic [15:0]         weight_q;
	logic [15:0]         gscale_q;
	logic                cfg_we;
	ifst_pkg::ifst_cmd_t cmd;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;
	assign prdata = paddr[2] ? {16'b0, gscale_q} : {16'b0, weight_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= ifst_pkg::WEIGHT_RESET;
			gscale_q <= ifst_pkg::GSCALE_RESET;
		end else if (cfg_we) begin
			if (paddr[2])
				gscale_q <= pwdata[15:0];
			else
				weight_q <= pwdata[15:0];
		end
	end

	ifst_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.frame_start(frame_start),
		.in_stall   (in_stall),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cmd        (cmd)
	);

	ifst_dp #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.data_byte       (data_byte),
		.smoothing_weight(weight_q),
		.gyro_scale      (gscale_q),
		.accel_x_smooth  (accel_x_smooth),
		.accel_y_smooth  (accel_y_smooth),
		.accel_z_smooth  (accel_z_smooth),
		.rate_x          (rate_x),
		.rate_y          (rate_y),
		.rate_z          (rate_z),
		.roll_angle      (roll_angle),
		.pitch_angle     (pitch_angle)
	);

endmodule
